// ----- design/moving_average_filter_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the moving average filter checker.
// ---------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_MACROS_SVH
`define MOVING_AVERAGE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/maf_pkg.sv -----
// ---------------------------------------------------------------------------
// maf_pkg
// Shared constants and types of the moving average filter.
// ---------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

	localparam int WINDOW_MAX_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 24;

	// Window length register.
	localparam int WIN_W = 9;
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1);

	// Status of the serial divider as seen by the controller.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

// ----- design/maf_ring.sv -----
// ---------------------------------------------------------------------------
// maf_ring
// Sample history memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module maf_ring #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 24
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/maf_divider.sv -----
// ---------------------------------------------------------------------------
// maf_divider
// Restoring divider, one quotient bit per cycle. A zero divisor gives zero.
// ---------------------------------------------------------------------------
`default_nettype none

module maf_divider #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 9,
	parameter int QUO_W = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 take,
	input  logic [NUM_W-1:0]     dividend,
	input  logic [DEN_W-1:0]     divisor,
	output maf_pkg::div_status_t status,
	output logic [QUO_W-1:0]     quotient
);

	import maf_pkg::*;

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic              zero_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  quo_q;

	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    diff;
	logic              fits;
	logic [DEN_W-1:0]  rem_nxt;

	// The quotient bits shift in from the right as the dividend bits leave.
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
		fits    = (shifted >= {1'b0, den_q});
		rem_nxt = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(NUM_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (take) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= rem_nxt;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = zero_q ? '0 : quo_q[QUO_W-1:0];

endmodule

`default_nettype wire

// ----- design/moving_average_filter.sv -----
// ---------------------------------------------------------------------------
// moving_average_filter
// Running mean of the last window_len samples of a series, truncated.
// ---------------------------------------------------------------------------
//
//   channel   signals                              direction
//   cfg       cfg_we, cfg_wdata                    in, write only
//   in        in_valid, in_ready, sample,          in
//             new_series
//   out       out_valid, out_ready, average        out
//
// Each item passes through the transfer with the ring read, the running-sum
// update and ring write, the steps of the bit-serial divider, and the load
// of the result; a new item is taken only once that load is done. After
// reset the block accepts at once; the ring needs no clearing pass. A
// stalled result waits in the output register while the next item is
// taken; the divider then holds its quotient until the output register
// frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module moving_average_filter #(
	parameter int WINDOW_MAX  = maf_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [maf_pkg::WIN_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [SAMPLE_BITS-1:0]    sample,
	input  logic                      new_series,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [SAMPLE_BITS-1:0]    average
);

	import maf_pkg::*;

	localparam int ADDR_W = $clog2(WINDOW_MAX);
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int IDX_W  = CNT_W + 1;
	localparam int CMP_W  = (WIN_W > CNT_W) ? WIN_W : CNT_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_UPDATE = 2'd1;
	localparam logic [1:0] ST_DIVIDE = 2'd2;

	logic [1:0]             state_q;
	logic [WIN_W-1:0]       window_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       seen_q;
	logic [ADDR_W-1:0]      slot_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] average_q;

	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SUM_W-1:0]       sum_s1;
	logic                   sub_s1;
	logic                   add_s1;
	logic [ADDR_W-1:0]      slot_s1;
	logic [CNT_W-1:0]       n_s1;

	logic                   accept;
	logic [CNT_W-1:0]       win_eff;
	logic [CNT_W-1:0]       cnt_eff;
	logic [ADDR_W-1:0]      slot_eff;
	logic [SUM_W-1:0]       sum_eff;
	logic [CNT_W-1:0]       cnt_next;
	logic [CNT_W-1:0]       n_next;
	logic [ADDR_W-1:0]      slot_next;
	logic [IDX_W-1:0]       old_full;
	logic [ADDR_W-1:0]      old_addr;
	logic                   sub_en;

	logic [SAMPLE_BITS-1:0] ring_rd_data;
	logic                   ring_wr_en;
	logic [SUM_W-1:0]       sum_new;

	logic                   div_start;
	logic                   out_load;
	div_status_t            div_st;
	logic [SAMPLE_BITS-1:0] div_quo;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Front end: series restart, window clamp and the slot that leaves the sum.
	always_comb begin
		if (CMP_W'(window_q) > CMP_W'(WINDOW_MAX)) begin
			win_eff = CNT_W'(WINDOW_MAX);
		end else begin
			win_eff = CNT_W'(window_q);
		end

		cnt_eff  = new_series ? '0 : seen_q;
		slot_eff = new_series ? '0 : slot_q;
		sum_eff  = new_series ? '0 : sum_q;

		cnt_next = (cnt_eff < CNT_W'(WINDOW_MAX)) ? cnt_eff + CNT_W'(1) : cnt_eff;
		n_next   = (cnt_next < win_eff) ? cnt_next : win_eff;
		sub_en   = (win_eff != '0) && (cnt_eff >= win_eff);

		if (IDX_W'(slot_eff) == IDX_W'(WINDOW_MAX - 1)) begin
			slot_next = '0;
		end else begin
			slot_next = slot_eff + ADDR_W'(1);
		end

		if (IDX_W'(slot_eff) >= IDX_W'(win_eff)) begin
			old_full = IDX_W'(slot_eff) - IDX_W'(win_eff);
		end else begin
			old_full = IDX_W'(slot_eff) + IDX_W'(WINDOW_MAX) - IDX_W'(win_eff);
		end
		old_addr = old_full[ADDR_W-1:0];
	end

	// The ring is read in the transfer cycle and written in the cycle after it,
	// so the read always sees the entry before this sample overwrites it.
	assign ring_wr_en = (state_q == ST_UPDATE);

	maf_ring #(
		.DEPTH  (WINDOW_MAX),
		.DATA_W (SAMPLE_BITS)
	) u_ring (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (old_addr),
		.rd_data (ring_rd_data),
		.wr_en   (ring_wr_en),
		.wr_addr (slot_s1),
		.wr_data (sample_s1)
	);

	always_comb begin
		sum_new = sum_s1;
		if (sub_s1) begin
			sum_new = sum_new - SUM_W'(ring_rd_data);
		end
		if (add_s1) begin
			sum_new = sum_new + SUM_W'(sample_s1);
		end
	end

	assign div_start = (state_q == ST_UPDATE);
	assign out_load  = (state_q == ST_DIVIDE) && !div_st.busy && div_st.done &&
		(!out_valid_q || out_ready);

	maf_divider #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W),
		.QUO_W (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.take     (out_load),
		.dividend (sum_new),
		.divisor  (n_s1),
		.status   (div_st),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			sum_s1    <= sum_eff;
			sub_s1    <= sub_en;
			add_s1    <= (win_eff != '0);
			slot_s1   <= slot_eff;
			n_s1      <= n_next;
		end
		if (out_load) begin
			average_q <= div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WIN_RESET;
			sum_q       <= '0;
			seen_q      <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						seen_q  <= cnt_next;
						slot_q  <= slot_next;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					sum_q   <= sum_new;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// A new window length restarts the series.
			if (cfg_we) begin
				window_q <= cfg_wdata;
				sum_q    <= '0;
				seen_q   <= '0;
				slot_q   <= '0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;

endmodule

`default_nettype wire

// ----- design/moving_average_filter_checker.sv -----
// ---------------------------------------------------------------------------
// moving_average_filter_checker
// Port-level checks on the moving average filter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "moving_average_filter_macros.svh"

module moving_average_filter_checker #(
	parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [SAMPLE_BITS-1:0] average
);

	// A result that is not taken stays put.
	`MAF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(average), "stalled result changed")

	// Items are handled one at a time, so a transfer closes the input.
	`MAF_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready, "input still open after a transfer")

	// The input closes only because an item was taken.
	`MAF_ASSERT_IMPLY(a_ready_fall, clk, arst_n, $fell(in_ready), $past(in_valid), "input closed without a transfer")

	// A result appears only while an item is in flight.
	`MAF_ASSERT_IMPLY(a_out_from_work, clk, arst_n, $rose(out_valid), $past(!in_ready), "result without an item in flight")

endmodule

bind moving_average_filter moving_average_filter_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.average   (average)
);

`default_nettype wire

// ----- tb/maf_checker.sv -----
// ---------------------------------------------------------------------------
// maf_checker
// Watches the configuration, sample and average channels of the moving
// average filter. It keeps its own copy of the window register, the sample
// ring and the running sum, predicts one average per accepted sample, and
// compares each average that leaves the block with the oldest prediction.
// ---------------------------------------------------------------------------

module maf_checker #(
	parameter int WINDOW_MAX  = maf_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [maf_pkg::WIN_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [SAMPLE_BITS-1:0]    sample,
	input  logic                      new_series,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [SAMPLE_BITS-1:0]    average,
	output int                        mismatches,
	output int                        pending
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int PRINT_MAX  = 50;

	logic [SAMPLE_BITS-1:0]    sample_ring [WINDOW_MAX];
	logic [SUM_W-1:0]          window_sum;
	int unsigned               series_count;
	int unsigned               ring_slot;
	logic [maf_pkg::WIN_W-1:0] window_len;
	logic [SAMPLE_BITS-1:0]    expected_averages [$];

	function automatic void restart_series();
		window_sum   = '0;
		series_count = 0;
		ring_slot    = 0;
	endfunction

	// Updates the running state with one sample and returns its average.
	function automatic logic [SAMPLE_BITS-1:0] predict_average(
		input logic [SAMPLE_BITS-1:0] value,
		input logic                   restart
	);
		int unsigned span;
		int unsigned divisor;
		int unsigned oldest;
		span = (window_len > WINDOW_MAX) ? WINDOW_MAX : window_len;
		if (restart) begin
			restart_series();
		end
		// The sum stays at zero while the window length is zero.
		if (span != 0) begin
			if (series_count >= span) begin
				oldest = (ring_slot + WINDOW_MAX - span) % WINDOW_MAX;
				window_sum -= sample_ring[oldest];
			end
			window_sum += value;
		end
		sample_ring[ring_slot] = value;
		ring_slot = (ring_slot + 1 == WINDOW_MAX) ? 0 : ring_slot + 1;
		if (series_count < WINDOW_MAX) begin
			series_count++;
		end
		divisor = (series_count < span) ? series_count : span;
		if (divisor == 0) begin
			return '0;
		end
		return SAMPLE_BITS'(window_sum / divisor);
	endfunction

	task automatic report_mismatch(input string detail);
		if (mismatches < PRINT_MAX) begin
			$display("[%0t] average check: %s", $realtime, detail);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [SAMPLE_BITS-1:0] expected;
		if (!arst_n) begin
			window_len = maf_pkg::WIN_RESET;
			restart_series();
			expected_averages.delete();
			pending <= 0;
		end else begin
			// A window write also starts a fresh series.
			if (cfg_we) begin
				window_len = cfg_wdata;
				restart_series();
			end
			if (in_valid && in_ready) begin
				expected_averages.push_back(predict_average(sample, new_series));
			end
			if (out_valid && out_ready) begin
				if (expected_averages.size() == 0) begin
					report_mismatch($sformatf("average %h with no sample outstanding",
						average));
				end else begin
					expected = expected_averages.pop_front();
					if (average !== expected) begin
						report_mismatch($sformatf("expected %h, got %h", expected,
							average));
					end
				end
			end
			pending <= expected_averages.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the moving average filter: a directed pass over the window
// extremes and the special cases, then random phases at several window
// lengths with random gaps on the sample side and random stalls on the
// average side. The checker beside the block scores every transfer.
// ---------------------------------------------------------------------------

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import maf_pkg::*;

	localparam int SB           = SAMPLE_BITS_DEF;
	localparam int QUIET_LIMIT  = 2000;
	localparam int LONG_HOLD    = 200;
	localparam int DRAIN_CYCLES = 40;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             cfg_we     = 1'b0;
	logic [WIN_W-1:0] cfg_wdata  = '0;
	logic             in_valid   = 1'b0;
	logic             in_ready;
	logic [SB-1:0]    sample     = '0;
	logic             new_series = 1'b0;
	logic             out_valid;
	logic             out_ready  = 1'b0;
	logic [SB-1:0]    average;

	int mismatches;
	int pending;
	bit idling        = 1'b1;
	bit stall_request = 1'b0;
	int ready_hold    = 0;
	int quiet_cycles  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	moving_average_filter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.new_series (new_series),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.average    (average)
	);

	maf_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.new_series (new_series),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.average    (average),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Average side: short random stalls, and one long hold-off on request.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			out_ready  <= 1'b0;
		end else if (stall_request) begin
			stall_request <= 1'b0;
			ready_hold    <= LONG_HOLD - 1;
			out_ready     <= 1'b0;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 3);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no transfer for %0d cycles", $realtime, QUIET_LIMIT);
			$display("moving_average_filter verification failed");
			$finish;
		end
	end

	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return SB'($urandom_range(0, 255));
			end
			3: begin
				return ~SB'($urandom_range(0, 255));
			end
			default: begin
				return SB'($urandom());
			end
		endcase
	endfunction

	// Returns at the edge where the sample transfer happens.
	task automatic send_sample(input logic [SB-1:0] value, input logic restart);
		int gap;
		if (idling && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		sample     <= value;
		new_series <= restart;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_window(input logic [WIN_W-1:0] len);
		in_valid <= 1'b0;
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(
		input logic [WIN_W-1:0] len,
		input int               items,
		input int               restart_odds,
		input bit               with_hold
	);
		set_window(len);
		for (int i = 0; i < items; i++) begin
			if (with_hold && i == 40) begin
				stall_request <= 1'b1;
			end
			send_sample(pick_sample(),
				restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
		end
	endtask

	initial begin
		int len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Window of one straight out of reset.
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		send_sample(24'hAAAAAA, 1'b1);
		send_sample(24'h555555, 1'b0);

		// Full-scale samples fill a short window; then a truncated mean.
		set_window(9'd4);
		for (int i = 0; i < 5; i++) begin
			send_sample('1, 1'b0);
		end
		send_sample(24'h000001, 1'b0);
		send_sample(24'h000003, 1'b1);
		send_sample(24'h000002, 1'b0);

		// A zero window forces zero averages.
		set_window(9'd0);
		send_sample('1, 1'b0);
		send_sample(24'h123456, 1'b1);

		// Lengths past the ring size act as the ring size.
		set_window(9'd511);
		send_sample('1, 1'b0);
		send_sample('0, 1'b0);
		send_sample(24'h800000, 1'b0);

		set_window(9'd256);
		send_sample('1, 1'b0);
		send_sample(24'h000001, 1'b0);

		// Long series so the write slot wraps under a short and a full window.
		run_phase(9'd7, 280, 0, 1'b0);
		run_phase(9'd256, 300, 0, 1'b1);
		run_phase(9'd0, 20, 8, 1'b0);
		run_phase(9'd257, 20, 40, 1'b0);

		idling = 1'b0;
		run_phase(9'd2, 30, 6, 1'b0);
		idling = 1'b1;

		len = $urandom_range(1, 20);
		run_phase(WIN_W'(len), 30, 2 * len + 4, 1'b0);
		len = $urandom_range(0, 511);
		run_phase(WIN_W'(len), 30, 2 * len + 4, 1'b0);

		// Closing stretch runs without gaps or stalls.
		idling = 1'b0;
		run_phase(9'd1, 20, 5, 1'b0);
		run_phase(9'd511, 40, 0, 1'b0);

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("moving_average_filter verification clean");
		end else begin
			$display("moving_average_filter verification failed");
		end
		$finish;
	end

endmodule
